// ===== sv/kdlpr_pkg.sv =====
// kdlpr_pkg: shared types and constants for the key debounce / long-press unit
// no dependencies; imported by every module of the block
package kdlpr_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CsrDebounce  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLongDelay = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRepeat    = 2'd2;

   // register reset values in ms
   localparam logic [CfgWidth-1:0] DebounceReset  = 16'd20;
   localparam logic [CfgWidth-1:0] LongDelayReset = 16'd100;
   localparam logic [CfgWidth-1:0] RepeatReset    = 16'd200;

   typedef struct packed {
      logic                 level;
      logic [TimeWidth-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic press_event;
      logic pressed;
      logic long_active;
   } rsp_type;

   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] long_delay_ms;
      logic [CfgWidth-1:0] repeat_ms;
   } cfg_type;

endpackage

// ===== sv/kdlpr_cfg.sv =====
// kdlpr_cfg: the three timing registers behind the csr write port
// depends on kdlpr_pkg
module kdlpr_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kdlpr_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [kdlpr_pkg::CfgWidth-1:0]       csr_wdata,
   output kdlpr_pkg::cfg_type                   cfg
);
   import kdlpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CsrDebounce:  cfg_in.debounce_ms   = csr_wdata;
            CsrLongDelay: cfg_in.long_delay_ms = csr_wdata;
            CsrRepeat:    cfg_in.repeat_ms     = csr_wdata;
            default:      cfg_in = cfg_ff;   // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DebounceReset;
         cfg_ff.long_delay_ms <= LongDelayReset;
         cfg_ff.repeat_ms     <= RepeatReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/kdlpr_step.sv =====
// kdlpr_step: key state registers and the per-item debounce / hold / repeat update
// depends on kdlpr_pkg
module kdlpr_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  kdlpr_pkg::req_type  item,
   input  kdlpr_pkg::cfg_type  cfg,
   output kdlpr_pkg::rsp_type  result
);
   import kdlpr_pkg::*;

   logic                 raw_last_ff,   raw_last_in;
   logic [TimeWidth-1:0] change_ff,     change_in;
   logic                 held_ff,       held_in;
   logic                 long_ff,       long_in;
   logic [TimeWidth-1:0] hold_start_ff, hold_start_in;
   logic [TimeWidth-1:0] repeat_ff,     repeat_in;

   logic                 raw_changed;
   logic [TimeWidth-1:0] stable_el;
   logic [TimeWidth-1:0] hold_el;
   logic [TimeWidth-1:0] repeat_el;
   logic                 stable;
   logic                 press;
   logic                 release_key;
   logic                 event_out;

   // all elapsed times taken against old state; a restart makes the
   // corresponding elapsed time zero, which never exceeds a threshold
   assign raw_changed = (item.level != raw_last_ff);
   assign stable_el   = item.now_ms - change_ff;
   assign hold_el     = item.now_ms - hold_start_ff;
   assign repeat_el   = item.now_ms - repeat_ff;
   assign stable      = !raw_changed &&
                        (stable_el > {{(TimeWidth-CfgWidth){1'b0}}, cfg.debounce_ms});
   assign press       = stable && !item.level && !held_ff;
   assign release_key = stable &&  item.level &&  held_ff;

   always_comb begin
      raw_last_in   = item.level;
      change_in     = raw_changed ? item.now_ms : change_ff;
      held_in       = held_ff;
      long_in       = long_ff;
      hold_start_in = hold_start_ff;
      repeat_in     = repeat_ff;
      event_out     = 1'b0;
      priority if (press) begin
         held_in       = 1'b1;
         long_in       = 1'b0;
         hold_start_in = item.now_ms;
         repeat_in     = item.now_ms;
         event_out     = 1'b1;
      end else if (release_key) begin
         held_in = 1'b0;
         long_in = 1'b0;
      end else if (held_ff && !long_ff) begin
         if (hold_el > {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_delay_ms}) begin
            long_in   = 1'b1;
            repeat_in = item.now_ms;
         end
      end else if (held_ff && long_ff) begin
         if (repeat_el > {{(TimeWidth-CfgWidth){1'b0}}, cfg.repeat_ms}) begin
            repeat_in = item.now_ms;
            event_out = 1'b1;
         end
      end else begin
         // key up and no debounced edge: state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff   <= 1'b0;
         change_ff     <= '0;
         held_ff       <= 1'b0;
         long_ff       <= 1'b0;
         hold_start_ff <= '0;
         repeat_ff     <= '0;
      end else if (step_en) begin
         raw_last_ff   <= raw_last_in;
         change_ff     <= change_in;
         held_ff       <= held_in;
         long_ff       <= long_in;
         hold_start_ff <= hold_start_in;
         repeat_ff     <= repeat_in;
      end
   end

   assign result.press_event = event_out;
   assign result.pressed     = held_in;
   assign result.long_active = long_in;

endmodule

// ===== sv/key_debounce_long_press_repeat_unit.sv =====
// key_debounce_long_press_repeat_unit: top level of the debounced key with auto-repeat
// depends on kdlpr_pkg, kdlpr_cfg, kdlpr_step
//
// Each item on req is one sample of the active-low key pin plus a free-running
// millisecond timestamp; each item produces exactly one rsp item with the press
// event pulse, the debounced pressed flag and the long-press flag. The unit takes
// one item per clock: a sample is held in an input register, goes through three
// parallel 32-bit elapsed-time subtract-and-compare paths against the key state,
// and lands in the result register, which drives rsp_valid and rsp_item. Only a
// stall on rsp slows the flow. The key state is written at the same edge as the
// result, so the next sample already sees it. Elapsed times wrap modulo 2^32
// and must strictly exceed the programmed thresholds. The timing registers
// (debounce, long delay, repeat interval, all in ms) are written over the csr
// port, which is always ready; write them only while no item is in flight.
module key_debounce_long_press_repeat_unit (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kdlpr_pkg::req_type                req_item,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kdlpr_pkg::rsp_type                rsp_item,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdlpr_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [kdlpr_pkg::CfgWidth-1:0]    csr_wdata
);
   import kdlpr_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff,  in_item_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff,  out_item_in;

   logic    out_free;   // result register can take a new item this cycle
   logic    step_en;    // item in the input register moves to the result register
   logic    req_take;
   rsp_type step_result;

   kdlpr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kdlpr_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // the whole path advances together whenever the result slot frees up
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_item_in  = step_result;
      end
      // input register loads whenever it is empty or moving on
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (step_en) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== sv/kdlpr_checker.sv =====
// kdlpr_checker: port-level assertions for the key debounce unit, bound to the top level
// depends on kdlpr_pkg and key_debounce_long_press_repeat_unit
module kdlpr_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input kdlpr_pkg::rsp_type rsp_item
);
   import kdlpr_pkg::*;

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // long mode only exists while the key is down
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.long_active && !rsp_item.pressed))
      else $error("long mode without pressed key");

   // every event leaves the key pressed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.press_event |-> rsp_item.pressed)
      else $error("press event with key released");

   // nothing comes out right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind key_debounce_long_press_repeat_unit kdlpr_checker u_kdlpr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
